// File: sv/dmchc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the direct-mapped cache hit counter.
// No dependencies; every other file imports this package.
package dmchc_pkg;

	// address and field widths
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TAG_W = 29;
	localparam int unsigned TAG_LSB = 3;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned OFFSET_W = 5;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned TAGBITS_W = 5;
	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned CFG_IDX_W = 2;

	// masked index value before folding onto the line count
	localparam int unsigned IDXV_W = 15;
	localparam int unsigned LO_W = 8;
	localparam int unsigned HI_W = IDXV_W - LO_W;

	localparam int unsigned LINES_DEFAULT = 1024;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS = 2'd2;

	// configuration reset values
	localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 5'd5;
	localparam logic [INDEX_W-1:0] INDEX_BITS_RST = 4'd10;
	localparam logic [TAGBITS_W-1:0] TAG_BITS_RST = 5'd17;

	// record kinds
	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_STORE = 2'd1,
		ACT_EMPTY = 2'd2,
		ACT_BAD = 2'd3
	} action_t;

	// one tag ram word
	typedef struct packed {
		logic valid;
		logic [TAG_W-1:0] tag;
	} line_t;

	// which statistics counters step for one record
	typedef struct packed {
		logic total;
		logic hit;
		logic read_hit;
		logic write_hit;
		logic read;
		logic write;
		logic unknown;
	} bump_t;

	// top min(t, 29) bits of the 29-bit tag field set
	function automatic logic [TAG_W-1:0] tag_mask(input logic [TAGBITS_W-1:0] t);
		logic [TAGBITS_W-1:0] tc;
		tc = (t > TAGBITS_W'(TAG_W)) ? TAGBITS_W'(TAG_W) : t;
		return ~({TAG_W{1'b1}} >> tc);
	endfunction

endpackage

// File: sv/direct_mapped_cache_hit_counter.sv
`timescale 1ns / 1ps
// Top level of the direct-mapped cache hit counter: config registers, pipeline,
// tag compare and line clear. Depends on dmchc_pkg, dmchc_index, dmchc_tag_ram, dmchc_stats.
//
//  channel   signals                                   direction
//  item      item_valid, item_stall, action, address   in (stall out)
//  result    result_valid, result_stall, hit, *_count  out (stall in)
//  config    cfg_write, cfg_index, cfg_data            in
//
// One record per cycle sustained while result_stall is low; result_valid rises after
// the record's transfer: the transfer loads the index stage, the advance into the
// compare stage reads the tag ram, and the advance out of it does the compare and
// counter update into the result register. After reset the tag ram is swept clear,
// one line a cycle; item_stall stays high meanwhile, config writes are taken as usual.
// result_stall backs up through the stages; the counters double as result register.
module direct_mapped_cache_hit_counter import dmchc_pkg::*; #(
	parameter int unsigned LINES = LINES_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic item_valid,
	output logic item_stall,
	input logic [1:0] action,
	input logic [ADDR_W-1:0] address,
	output logic result_valid,
	input logic result_stall,
	output logic hit,
	output logic [CNT_W-1:0] total_count,
	output logic [CNT_W-1:0] hit_count,
	output logic [CNT_W-1:0] read_hit_count,
	output logic [CNT_W-1:0] write_hit_count,
	output logic [CNT_W-1:0] read_count,
	output logic [CNT_W-1:0] write_count,
	output logic [CNT_W-1:0] unknown_count
);

	localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINES - 1);

	logic [OFFSET_W-1:0] offset_bits_q;
	logic [INDEX_W-1:0] index_bits_q;
	logic [TAGBITS_W-1:0] tag_bits_q;

	logic clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic valid_s1;
	action_t act_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [IDX_W-1:0] idx_s1;
	logic valid_s2;
	action_t act_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [IDX_W-1:0] idx_s2;
	logic out_valid_q;
	logic hit_q;

	logic [IDX_W-1:0] in_idx;
	logic item_xfer;
	logic out_free;
	logic s2_adv;
	logic s2_free;
	logic s1_adv;
	logic s1_free;

	line_t rd_line;
	line_t wr_line;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [TAG_W-1:0] tmask;
	logic [TAG_W-1:0] want;
	logic is_load;
	logic is_write;
	logic is_mem;
	logic hit_w;
	bump_t bump;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q <= INDEX_BITS_RST;
			tag_bits_q <= TAG_BITS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data[OFFSET_W-1:0];
				REG_INDEX_BITS: index_bits_q <= cfg_data[INDEX_W-1:0];
				REG_TAG_BITS: tag_bits_q <= cfg_data[TAGBITS_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing sweep over the tag ram after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == LAST_LINE) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// stage flow control
	assign out_free = !out_valid_q || !result_stall;
	assign s2_adv = valid_s2 && out_free;
	assign s2_free = !valid_s2 || s2_adv;
	assign s1_adv = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || s1_adv;
	assign item_stall = clr_q || !s1_free;
	assign item_xfer = item_valid && !item_stall;

	// line index of the incoming record
	dmchc_index #(
		.LINES(LINES)
	) u_index (
		.address(address),
		.offset_bits(offset_bits_q),
		.index_bits(index_bits_q),
		.line_idx(in_idx)
	);

	// stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			act_s1 <= action_t'(action);
			addr_s1 <= address;
			idx_s1 <= in_idx;
		end
		if (s1_adv) begin
			act_s2 <= act_s1;
			addr_s2 <= addr_s1;
			idx_s2 <= idx_s1;
		end
		if (s2_adv) begin
			hit_q <= hit_w;
		end
	end

	// tag ram, read as a record enters the compare stage
	dmchc_tag_ram #(
		.LINES(LINES)
	) u_tag_ram (
		.clk(clk),
		.rd_en(s1_adv),
		.rd_idx(idx_s1),
		.rd_data(rd_line),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_line)
	);

	// tag compare
	assign is_load = (act_s2 == ACT_LOAD);
	assign is_write = (act_s2 == ACT_STORE);
	assign is_mem = is_load || is_write;
	assign tmask = tag_mask(tag_bits_q);
	assign want = addr_s2[ADDR_W-1:TAG_LSB] & tmask;
	assign hit_w = is_mem && rd_line.valid && ((rd_line.tag & tmask) == want);

	// line fill on a miss, or the clearing sweep
	always_comb begin
		if (clr_q) begin
			wr_en = 1'b1;
			wr_idx = clr_idx_q;
			wr_line = '0;
		end else begin
			wr_en = s2_adv && is_mem && !hit_w;
			wr_idx = idx_s2;
			wr_line.valid = 1'b1;
			wr_line.tag = (rd_line.tag & ~tmask) | want;
		end
	end

	// counter steps for this record
	always_comb begin
		bump.total = 1'b1;
		bump.hit = hit_w;
		bump.read_hit = hit_w && is_load;
		bump.write_hit = hit_w && is_write;
		bump.read = is_load;
		bump.write = is_write;
		bump.unknown = (act_s2 == ACT_EMPTY);
	end

	dmchc_stats u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.en(s2_adv),
		.bump(bump),
		.total_count(total_count),
		.hit_count(hit_count),
		.read_hit_count(read_hit_count),
		.write_hit_count(write_hit_count),
		.read_count(read_count),
		.write_count(write_count),
		.unknown_count(unknown_count)
	);

	assign result_valid = out_valid_q;
	assign hit = hit_q;

	// no record may be in flight while the tag ram is being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!valid_s1 && !valid_s2 && !out_valid_q))
		else $error("record in flight during tag ram clear");

	// a new result only follows a record leaving the compare stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_adv))
		else $error("result valid without a finished record");

	// the record count never goes backwards
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_count >= $past(total_count)))
		else $error("total count decreased");

	// a reported hit has been counted
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_q) |-> (hit_count != '0))
		else $error("hit reported with zero hit count");

endmodule

// File: sv/dmchc_index.sv
`timescale 1ns / 1ps
// Line index generation: offset shift, index mask and fold onto the line count.
// Depends on dmchc_pkg.
module dmchc_index import dmchc_pkg::*; #(
	parameter int unsigned LINES = LINES_DEFAULT
) (
	input logic [ADDR_W-1:0] address,
	input logic [OFFSET_W-1:0] offset_bits,
	input logic [INDEX_W-1:0] index_bits,
	output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] line_idx
);

	localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int unsigned LO_N = 1 << LO_W;
	localparam int unsigned HI_N = 1 << HI_W;
	localparam logic [IDX_W:0] LINES_V = (IDX_W + 1)'(LINES);

	logic [ADDR_W-1:0] shifted;
	logic [IDXV_W-1:0] vmask;
	logic [IDXV_W-1:0] val;
	logic [IDX_W-1:0] lo_rem [LO_N];
	logic [IDX_W-1:0] hi_rem [HI_N];
	logic [IDX_W:0] sum;
	logic [IDX_W:0] folded;

	// select the index field of the address
	assign shifted = address >> offset_bits;
	assign vmask = ~({IDXV_W{1'b1}} << index_bits);
	assign val = shifted[IDXV_W-1:0] & vmask;

	// remainder tables for the low byte and the upper bits
	for (genvar i = 0; i < LO_N; i++) begin : g_lo
		localparam int unsigned REM = i % LINES;
		assign lo_rem[i] = IDX_W'(REM);
	end
	for (genvar j = 0; j < HI_N; j++) begin : g_hi
		localparam int unsigned REM = (j * LO_N) % LINES;
		assign hi_rem[j] = IDX_W'(REM);
	end

	// both parts are below the line count, so one subtract finishes the fold
	assign sum = {1'b0, lo_rem[val[LO_W-1:0]]} + {1'b0, hi_rem[val[IDXV_W-1:LO_W]]};
	assign folded = (sum >= LINES_V) ? (sum - LINES_V) : sum;
	assign line_idx = folded[IDX_W-1:0];

endmodule

// File: sv/dmchc_tag_ram.sv
`timescale 1ns / 1ps
// Tag ram: one write port and one registered read port, write data forwarded
// to a read of the same line in the same cycle. Depends on dmchc_pkg.
module dmchc_tag_ram import dmchc_pkg::*; #(
	parameter int unsigned LINES = LINES_DEFAULT
) (
	input logic clk,
	input logic rd_en,
	input logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] rd_idx,
	output line_t rd_data,
	input logic wr_en,
	input logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] wr_idx,
	input line_t wr_data
);

	line_t mem [LINES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// read port, new data on a same-line collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_idx];
			end
		end
	end

endmodule

// File: sv/dmchc_stats.sv
`timescale 1ns / 1ps
// Seven saturating statistics counters stepped once per finished record.
// Depends on dmchc_pkg.
module dmchc_stats import dmchc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input bump_t bump,
	output logic [CNT_W-1:0] total_count,
	output logic [CNT_W-1:0] hit_count,
	output logic [CNT_W-1:0] read_hit_count,
	output logic [CNT_W-1:0] write_hit_count,
	output logic [CNT_W-1:0] read_count,
	output logic [CNT_W-1:0] write_count,
	output logic [CNT_W-1:0] unknown_count
);

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] read_hit_q;
	logic [CNT_W-1:0] write_hit_q;
	logic [CNT_W-1:0] read_q;
	logic [CNT_W-1:0] write_q;
	logic [CNT_W-1:0] unknown_q;

	// counters hold at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			hit_q <= '0;
			read_hit_q <= '0;
			write_hit_q <= '0;
			read_q <= '0;
			write_q <= '0;
			unknown_q <= '0;
		end else if (en) begin
			if (bump.total && (total_q != '1)) total_q <= total_q + 1'b1;
			if (bump.hit && (hit_q != '1)) hit_q <= hit_q + 1'b1;
			if (bump.read_hit && (read_hit_q != '1)) read_hit_q <= read_hit_q + 1'b1;
			if (bump.write_hit && (write_hit_q != '1)) write_hit_q <= write_hit_q + 1'b1;
			if (bump.read && (read_q != '1)) read_q <= read_q + 1'b1;
			if (bump.write && (write_q != '1)) write_q <= write_q + 1'b1;
			if (bump.unknown && (unknown_q != '1)) unknown_q <= unknown_q + 1'b1;
		end
	end

	assign total_count = total_q;
	assign hit_count = hit_q;
	assign read_hit_count = read_hit_q;
	assign write_hit_count = write_hit_q;
	assign read_count = read_q;
	assign write_count = write_q;
	assign unknown_count = unknown_q;

endmodule
